// ===== sv/bal_pkg.sv =====
// Shared types and constants for the bump allocator block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package bal_pkg;

   localparam int WORD_BITS = 32;
   localparam int SIZE_BITS = 24;
   localparam int WIDE_BITS = WORD_BITS + 1;

   localparam int ALIGN_MASK_DEF  = 7;
   localparam int CHUNK_BYTES_DEF = 4096;
   localparam int ADDR_BITS_DEF   = 32;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_RESIZE = 2'd1,
      OP_FREE   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOMEM   = 2'd1,
      ST_NOTLAST = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   typedef enum logic {
      CSR_HEAP_BASE  = 1'b0,
      CSR_HEAP_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]           op;
      logic [SIZE_BITS-1:0] size;
      logic [WORD_BITS-1:0] block_addr;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] addr;
      logic [1:0]           status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic prep;
      logic plan;
      logic check;
      logic raise;
      logic commit;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic simple;      // request finishes without the sizing steps
      logic need_raise;  // free space short, break must move
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== sv/bump_allocator_last_block_core.sv =====
// Top level of the bump-pointer arena allocator (last-block resize/free).
// Depends on bal_pkg, bal_ctrl and bal_datapath.
//
// Request channel: drive req_data and raise start; the request transfers on a
// rising edge with start high and busy low. busy stays high while the request
// is worked on and drops in the cycle the result is shown.
// Result channel: rsp_valid pulses for exactly one cycle with rsp_data; the
// receiver has no way to stall, so it must take the result in that cycle.
// Controller states after the transfer edge (rsp_valid follows COMMIT):
//   free, op 3, address mismatch, shrink or equal resize: PREP, COMMIT
//   allocate/grow with space available: PREP, PLAN, CHECK, COMMIT
//   allocate/grow that raises the break: PREP, PLAN, CHECK, RAISE, COMMIT
// The next request can transfer in the cycle the result is shown; the
// steps are set by the controller walking the datapath through align,
// plan, chunk sizing and break raise.
// Config: csr_valid/csr_ready with csr_index (0 heap_base, 1 heap_limit) and
// csr_wdata; csr_ready is high whenever no request is in flight. Writing
// heap_base before the first allocation also reloads the break pointer.
// Reset (synchronous, active high) clears the arena state and the break
// pointer, sets heap_limit to all ones, and leaves the block idle.
`default_nettype none

module bump_allocator_last_block_core #(
   parameter int ALIGN_MASK  = bal_pkg::ALIGN_MASK_DEF,
   parameter int CHUNK_BYTES = bal_pkg::CHUNK_BYTES_DEF,
   parameter int ADDR_BITS   = bal_pkg::ADDR_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          start,
   output logic                               busy,
   input  wire bal_pkg::req_type              req_data,
   // result channel
   output logic                               rsp_valid,
   output bal_pkg::rsp_type                   rsp_data,
   // config write channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic                          csr_index,
   input  wire logic [bal_pkg::WORD_BITS-1:0] csr_wdata
);

   bal_pkg::ctrl_cmd_type cmd;
   bal_pkg::dp_stat_type  stat;

   // config only transfers between requests
   assign csr_ready = !busy;

   bal_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bal_datapath #(
      .ALIGN_MASK  (ALIGN_MASK),
      .CHUNK_BYTES (CHUNK_BYTES),
      .ADDR_BITS   (ADDR_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/bal_ctrl.sv =====
// Sequencer for the bump allocator: steps one request through the datapath.
// Depends on bal_pkg (command and status structs).
`default_nettype none

module bal_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire bal_pkg::dp_stat_type  stat,
   output bal_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_PREP   = 6'b000010,
      S_PLAN   = 6'b000100,
      S_CHECK  = 6'b001000,
      S_RAISE  = 6'b010000,
      S_COMMIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = S_PREP;
         S_PREP:   state_in = stat.simple ? S_COMMIT : S_PLAN;
         S_PLAN:   state_in = S_CHECK;
         S_CHECK:  state_in = stat.need_raise ? S_RAISE : S_COMMIT;
         S_RAISE:  state_in = S_COMMIT;
         S_COMMIT: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign cmd.load   = (state_ff == S_IDLE) && start;
   assign cmd.prep   = (state_ff == S_PREP);
   assign cmd.plan   = (state_ff == S_PLAN);
   assign cmd.check  = (state_ff == S_CHECK);
   assign cmd.raise  = (state_ff == S_RAISE);
   assign cmd.commit = (state_ff == S_COMMIT);

endmodule

`default_nettype wire

// ===== sv/bal_datapath.sv =====
// Datapath of the bump allocator: arena state, config registers, request
// staging, sizing arithmetic and the result register. Depends on bal_pkg.
`default_nettype none

module bal_datapath #(
   parameter int ALIGN_MASK  = bal_pkg::ALIGN_MASK_DEF,
   parameter int CHUNK_BYTES = bal_pkg::CHUNK_BYTES_DEF,
   parameter int ADDR_BITS   = bal_pkg::ADDR_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bal_pkg::ctrl_cmd_type         cmd,
   output bal_pkg::dp_stat_type               stat,
   input  wire bal_pkg::req_type              req_data,
   input  wire logic                          csr_write,
   input  wire logic                          csr_index,
   input  wire logic [bal_pkg::WORD_BITS-1:0] csr_wdata,
   output logic                               rsp_valid,
   output bal_pkg::rsp_type                   rsp_data
);

   localparam int W  = bal_pkg::WORD_BITS;
   localparam int WW = bal_pkg::WIDE_BITS;
   localparam int SB = bal_pkg::SIZE_BITS;

   localparam logic [63:0]   MASK64 = (ADDR_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                        : ((64'd1 << ADDR_BITS) - 64'd1);
   localparam logic [W-1:0]  ADDR_MASK = MASK64[W-1:0];
   localparam logic [WW-1:0] CHUNK     = WW'(CHUNK_BYTES);
   localparam logic [5:0]    AMASK     = 6'(ALIGN_MASK);
   localparam logic [6:0]    ASTEP     = 7'(ALIGN_MASK) + 7'd1;

   // round up to the alignment; x stays below 2^32 so the result fits
   function automatic logic [WW-1:0] align_up(input logic [WW-1:0] x);
      logic [5:0] r;
      logic [6:0] inc;
      r   = x[5:0] & AMASK;
      inc = (r == 6'd0) ? 7'd0 : (ASTEP - {1'b0, r});
      return x + WW'(inc);
   endfunction

   // config; heap_base only matters through the break it loads
   logic [W-1:0] heap_limit_ff;
   logic [W-1:0] top_addr;

   // arena state
   logic [W-1:0] free_ptr_ff, free_count_ff, last_addr_ff, last_size_ff, break_ptr_ff;
   logic         started_ff;

   // staged request
   bal_pkg::op_type       op_ff;
   logic [SB-1:0]         size_ff;
   logic [W-1:0]          ba_ff;

   // prep results
   logic [WW-1:0] n_ff, ab_ff;
   logic [W-1:0]  gap_ff;
   logic          match_ff, eq_ff, grow_ff;

   // plan / check / raise
   logic [WW-1:0] need_ff, brk_ff, avail_ff, amt_ff;
   logic [W-1:0]  base_ff;
   logic          fail_ff;

   logic          rsp_valid_ff;
   bal_pkg::rsp_type rsp_ff, rsp_in;

   logic          match_c, grow_c;
   logic [W-1:0]  size_w;
   logic [WW-1:0] nb_c;

   assign top_addr = heap_limit_ff & ADDR_MASK;
   assign size_w   = W'(size_ff);
   assign match_c  = (last_addr_ff != '0) && (ba_ff == last_addr_ff);
   assign grow_c   = (size_w > last_size_ff);
   assign nb_c     = brk_ff + amt_ff;

   assign stat.simple = !((op_ff == bal_pkg::OP_ALLOC) ||
                          ((op_ff == bal_pkg::OP_RESIZE) && match_c && grow_c));
   assign stat.need_raise = (avail_ff < need_ff);

   // request staging and sizing steps
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= bal_pkg::op_type'(req_data.op);
         size_ff <= req_data.size;
         ba_ff   <= req_data.block_addr;
      end
      if (cmd.prep) begin
         n_ff     <= align_up(WW'(size_ff));
         ab_ff    <= align_up({1'b0, break_ptr_ff});
         gap_ff   <= grow_c ? (size_w - last_size_ff) : (last_size_ff - size_w);
         match_ff <= match_c;
         eq_ff    <= (size_w == last_size_ff);
         grow_ff  <= grow_c;
      end
      if (cmd.plan) begin
         if (op_ff == bal_pkg::OP_ALLOC) begin
            need_ff <= n_ff;
            if (started_ff) begin
               base_ff  <= free_ptr_ff;
               brk_ff   <= {1'b0, break_ptr_ff};
               avail_ff <= {1'b0, free_count_ff};
               fail_ff  <= 1'b0;
            end else begin
               // first allocation aligns the break before anything else
               base_ff  <= ab_ff[W-1:0];
               brk_ff   <= ab_ff;
               avail_ff <= '0;
               fail_ff  <= (ab_ff != {1'b0, break_ptr_ff}) && (ab_ff > {1'b0, top_addr});
            end
         end else begin
            need_ff  <= align_up({1'b0, gap_ff});
            base_ff  <= last_addr_ff;
            brk_ff   <= {1'b0, break_ptr_ff};
            avail_ff <= {1'b0, free_count_ff};
            fail_ff  <= 1'b0;
         end
      end
      if (cmd.check) begin
         amt_ff <= (need_ff <= CHUNK) ? CHUNK : need_ff;
      end
      if (cmd.raise) begin
         brk_ff   <= nb_c;
         avail_ff <= avail_ff + amt_ff;
         fail_ff  <= fail_ff || (nb_c > {1'b0, top_addr});
      end
   end

   // arena state, config and result
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= '1;
         free_ptr_ff   <= '0;
         free_count_ff <= '0;
         last_addr_ff  <= '0;
         last_size_ff  <= '0;
         break_ptr_ff  <= '0;
         started_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (csr_write) begin
            unique case (bal_pkg::csr_index_type'(csr_index))
               bal_pkg::CSR_HEAP_BASE: begin
                  if (!started_ff) break_ptr_ff <= csr_wdata & ADDR_MASK;
               end
               bal_pkg::CSR_HEAP_LIMIT: heap_limit_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.commit) begin
            case (op_ff)
               bal_pkg::OP_ALLOC: begin
                  if (!fail_ff) begin
                     started_ff    <= 1'b1;
                     break_ptr_ff  <= brk_ff[W-1:0];
                     last_addr_ff  <= base_ff;
                     last_size_ff  <= need_ff[W-1:0];
                     free_ptr_ff   <= base_ff + need_ff[W-1:0];
                     free_count_ff <= avail_ff[W-1:0] - need_ff[W-1:0];
                  end
               end
               bal_pkg::OP_RESIZE: begin
                  if (match_ff && !eq_ff) begin
                     if (grow_ff) begin
                        if (!fail_ff) begin
                           break_ptr_ff  <= brk_ff[W-1:0];
                           free_ptr_ff   <= free_ptr_ff + need_ff[W-1:0];
                           last_size_ff  <= last_size_ff + need_ff[W-1:0];
                           free_count_ff <= avail_ff[W-1:0] - need_ff[W-1:0];
                        end
                     end else begin
                        // shrink to the exact size, no alignment
                        free_ptr_ff   <= free_ptr_ff - gap_ff;
                        last_size_ff  <= size_w;
                        free_count_ff <= free_count_ff + gap_ff;
                     end
                  end
               end
               bal_pkg::OP_FREE: begin
                  if (match_ff) begin
                     free_count_ff <= free_count_ff + last_size_ff;
                     free_ptr_ff   <= last_addr_ff;
                     last_size_ff  <= '0;
                     last_addr_ff  <= '0;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      rsp_in.addr   = '0;
      rsp_in.status = bal_pkg::ST_OK;
      case (op_ff)
         bal_pkg::OP_ALLOC: begin
            if (fail_ff) rsp_in.status = bal_pkg::ST_NOMEM;
            else         rsp_in.addr   = base_ff;
         end
         bal_pkg::OP_RESIZE: begin
            if (!match_ff)                   rsp_in.status = bal_pkg::ST_NOTLAST;
            else if (grow_ff && fail_ff)     rsp_in.status = bal_pkg::ST_NOMEM;
            else                             rsp_in.addr   = last_addr_ff;
         end
         bal_pkg::OP_FREE: begin
            if (!match_ff) rsp_in.status = bal_pkg::ST_NOTLAST;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/bal_checker.sv =====
// Port-level checks for the bump allocator top level, attached by bind.
// Depends on bal_pkg and bump_allocator_last_block_core.
`default_nettype none

module bal_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire bal_pkg::rsp_type rsp_data
);

   // a transferred request raises busy in the cycle after it
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after request transfer");

   // result shows exactly when the block comes free
   a_fell_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("block went idle without a result");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // one result per request: rsp_valid falls after every strobe
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != bal_pkg::ST_OK) |-> (rsp_data.addr == '0))
      else $error("failed request returned a nonzero address");

endmodule

bind bump_allocator_last_block_core bal_checker u_bal_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for bump_allocator_last_block_core.
// Needs bal_pkg and the RTL; a directed table, then randomized phases, each result checked
// against an in-bench arena model or a typed expectation.
`timescale 1ns / 100ps

module tb_top;

   localparam logic [63:0] WORD_MASK     = 64'hFFFF_FFFF;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          SETTLE_CYCLES = 16;     // longer than the worst-case result delay
   localparam int          REPORT_MAX    = 10;
   localparam int          PHASES        = 6;

   // one expected result, tagged with the sequence number of its request
   typedef struct packed {
      bal_pkg::rsp_type rsp;
      logic [31:0]      seq;
   } grant_entry_type;

   // one directed step: either a register write or a request
   typedef struct packed {
      bit                     is_reg;
      bal_pkg::csr_index_type reg_idx;
      logic [31:0]            reg_val;
      bal_pkg::req_type       req;
      bit                     at_last;     // block_addr is replaced by the current last block
      bit                     fixed;       // typed_rsp is the expected result
      bal_pkg::rsp_type       typed_rsp;
   } step_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   bal_pkg::req_type req_data;
   logic             rsp_valid;
   bal_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic             csr_index;
   logic [31:0]      csr_wdata;

   bump_allocator_last_block_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Arena model. 64-bit arithmetic so that carries past 32 bits are seen.
   // Updated at the edge where a request or register write transfers.
   // ---------------------------------------------------------------------
   logic [63:0] arena_base;
   logic [63:0] arena_limit;
   logic [63:0] arena_free_ptr;
   logic [63:0] arena_free_count;
   logic [63:0] arena_last_addr;
   logic [63:0] arena_last_size;
   logic [63:0] arena_break;
   bit          arena_started;

   grant_entry_type grant_q[$];
   step_row_type    directed_rows[$];

   bit          start_level;
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned directed_sent;
   int unsigned results_seen;
   int unsigned nomem_seen;
   int unsigned notlast_seen;
   int unsigned reg_writes;
   int unsigned drain_pauses;
   int unsigned cycle_count;

   function automatic logic [63:0] round_up8(logic [63:0] x);
      logic [63:0] rem;
      rem = x & 64'(bal_pkg::ALIGN_MASK_DEF);
      return (rem == 64'd0) ? x : x + 64'(bal_pkg::ALIGN_MASK_DEF) + 64'd1 - rem;
   endfunction

   // growth always takes at least one chunk
   function automatic logic [63:0] chunk_for_need(logic [63:0] need);
      return (need <= 64'(bal_pkg::CHUNK_BYTES_DEF)) ? 64'(bal_pkg::CHUNK_BYTES_DEF) : need;
   endfunction

   // a new break must stay inside the address range and under heap_limit
   function automatic bit break_fits(logic [63:0] nb);
      return (nb <= WORD_MASK) && (nb <= (arena_limit & WORD_MASK));
   endfunction

   function automatic void arena_set_reg(bal_pkg::csr_index_type idx, logic [31:0] val);
      if (idx == bal_pkg::CSR_HEAP_BASE) begin
         arena_base = {32'd0, val};
         // base only moves the break before the first allocation
         if (!arena_started) arena_break = arena_base & WORD_MASK;
      end else begin
         arena_limit = {32'd0, val};
      end
   endfunction

   // Works out the result of one request and advances the arena state.
   // Failures return early so nothing is committed.
   function automatic bal_pkg::rsp_type arena_grant(bal_pkg::req_type r);
      logic [63:0]      want;
      logic [63:0]      base;
      logic [63:0]      avail;
      logic [63:0]      brk;
      logic [63:0]      aligned;
      logic [63:0]      amt;
      logic [63:0]      delta;
      logic [63:0]      rsize;
      bal_pkg::rsp_type g;
      g.addr   = '0;
      g.status = bal_pkg::ST_OK;
      rsize    = {40'd0, r.size};
      case (r.op)
         bal_pkg::OP_ALLOC: begin
            want = round_up8(rsize);
            if (arena_started) begin
               base  = arena_free_ptr;
               avail = arena_free_count;
               brk   = arena_break;
            end else begin
               // first allocation aligns the base, even for size zero
               aligned = round_up8(arena_break);
               if (aligned != arena_break && !break_fits(aligned)) begin
                  g.status = bal_pkg::ST_NOMEM;
                  return g;
               end
               brk   = aligned;
               base  = aligned;
               avail = '0;
            end
            if (avail < want) begin
               amt = chunk_for_need(want);
               if (!break_fits(brk + amt)) begin
                  g.status = bal_pkg::ST_NOMEM;
                  return g;
               end
               brk   = brk + amt;
               avail = avail + amt;
            end
            arena_started    = 1'b1;
            arena_break      = brk;
            arena_last_addr  = base;
            arena_last_size  = want;
            arena_free_ptr   = base + want;
            arena_free_count = avail - want;
            g.addr = base[31:0];
         end
         bal_pkg::OP_RESIZE: begin
            if (arena_last_addr == 0 || {32'd0, r.block_addr} != arena_last_addr) begin
               g.status = bal_pkg::ST_NOTLAST;
               return g;
            end
            if (rsize > arena_last_size) begin
               // growth is by the aligned difference
               delta = round_up8(rsize - arena_last_size);
               if (arena_free_count < delta) begin
                  amt = chunk_for_need(delta);
                  if (!break_fits(arena_break + amt)) begin
                     g.status = bal_pkg::ST_NOMEM;
                     return g;
                  end
                  arena_break      = arena_break + amt;
                  arena_free_count = arena_free_count + amt;
               end
               arena_free_ptr   = arena_free_ptr + delta;
               arena_last_size  = arena_last_size + delta;
               arena_free_count = arena_free_count - delta;
            end else if (rsize < arena_last_size) begin
               // shrink is exact, no alignment
               delta            = arena_last_size - rsize;
               arena_free_ptr   = arena_free_ptr - delta;
               arena_last_size  = rsize;
               arena_free_count = arena_free_count + delta;
            end
            g.addr = arena_last_addr[31:0];
         end
         bal_pkg::OP_FREE: begin
            if (arena_last_addr == 0 || {32'd0, r.block_addr} != arena_last_addr) begin
               g.status = bal_pkg::ST_NOTLAST;
               return g;
            end
            arena_free_count = arena_free_count + arena_last_size;
            arena_free_ptr   = arena_last_addr;
            arena_last_size  = '0;
            arena_last_addr  = '0;
         end
         default: ;  // unused opcode: no change, addr 0, ok
      endcase
      return g;
   endfunction

   // ---------------------------------------------------------------------
   // Drivers. All block inputs change by NBA right after a rising edge;
   // start_level shadows start so it gets at most one NBA per edge.
   // ---------------------------------------------------------------------
   function automatic void note_failure(string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("%s", msg);
   endfunction

   task automatic drive_start(bit level);
      if (start_level != level) begin
         start       <= level;
         start_level  = level;
      end
   endtask

   // sender idles while a random draw under 100 falls below pct
   task automatic sender_idle(int pct);
      while ($urandom_range(0, 99) < pct) begin
         drive_start(1'b0);
         @(posedge clock);
      end
   endtask

   // hold requests back until every outstanding result has come out
   task automatic wait_all_granted();
      drive_start(1'b0);
      while (grant_q.size() != 0) @(posedge clock);
   endtask

   // Present one request and hold it until it transfers (start high, busy low).
   task automatic issue(bal_pkg::req_type r, bit at_last, bit fixed,
                        bal_pkg::rsp_type typed_rsp);
      grant_entry_type  e;
      bal_pkg::rsp_type predicted;
      if (at_last) r.block_addr = arena_last_addr[31:0];
      req_data <= r;
      drive_start(1'b1);
      do @(posedge clock); while (busy !== 1'b0);
      predicted = arena_grant(r);
      e.rsp     = fixed ? typed_rsp : predicted;
      e.seq     = items_sent;
      items_sent++;
      grant_q.push_back(e);
   endtask

   // Register write, only with the block drained. keep leaves csr_valid high
   // for a write that follows straight away.
   task automatic program_reg(bal_pkg::csr_index_type idx, logic [31:0] val, bit keep);
      wait_all_granted();
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      arena_set_reg(idx, val);
      reg_writes++;
      if (!keep) csr_valid <= 1'b0;
   endtask

   function automatic step_row_type row_req(bal_pkg::op_type op, logic [23:0] size,
                                            logic [31:0] addr, bit at_last, bit fixed,
                                            logic [31:0] exp_addr,
                                            bal_pkg::status_type exp_status);
      step_row_type s;
      s                  = '0;
      s.req.op           = op;
      s.req.size         = size;
      s.req.block_addr   = addr;
      s.at_last          = at_last;
      s.fixed            = fixed;
      s.typed_rsp.addr   = exp_addr;
      s.typed_rsp.status = exp_status;
      return s;
   endfunction

   function automatic step_row_type row_reg(bal_pkg::csr_index_type idx, logic [31:0] val);
      step_row_type s;
      s         = '0;
      s.is_reg  = 1'b1;
      s.reg_idx = idx;
      s.reg_val = val;
      return s;
   endfunction

   // Mostly well-formed traffic on the last block; some mismatched addresses,
   // unused opcodes and raw noise. heavy biases toward huge allocations.
   function automatic bal_pkg::req_type random_request(bit heavy);
      logic [31:0]      noise;
      logic [23:0]      sz;
      int unsigned      pick;
      int unsigned      nudge;
      bal_pkg::req_type r;
      noise = $urandom();
      pick  = $urandom_range(0, 99);
      nudge = $urandom_range(0, 2);
      if (heavy && pick < 85)  sz = 24'hF0_0000 | noise[23:0];
      else if (pick < 50)      sz = 24'($urandom_range(0, 40));
      else if (pick < 75)      sz = 24'($urandom_range(41, 6000));
      else if (pick < 88)      sz = arena_last_size[23:0] + nudge[23:0] - 24'd1;  // equal or +-1
      else if (pick < 94)      sz = (noise[0]) ? 24'hFF_FFFF : 24'h00_0000;
      else                     sz = noise[23:0];
      r.size       = sz;
      r.block_addr = arena_last_addr[31:0];
      pick = $urandom_range(0, 99);
      if (pick < (heavy ? 75 : 40)) begin
         r.op         = bal_pkg::OP_ALLOC;
         r.block_addr = $urandom();
      end else if (pick < 80) begin
         r.op = bal_pkg::OP_RESIZE;
      end else if (pick < 88) begin
         r.op = bal_pkg::OP_FREE;
      end else if (pick < 92) begin
         // near miss: last block address with one bit flipped
         r.op         = noise[31] ? bal_pkg::OP_RESIZE : bal_pkg::OP_FREE;
         r.block_addr = arena_last_addr[31:0] ^ (32'd1 << $urandom_range(0, 31));
      end else if (pick < 95) begin
         r.op         = bal_pkg::OP_NONE;
         r.block_addr = $urandom();
      end else begin
         r.op         = 2'($urandom_range(0, 3));
         r.size       = 24'($urandom());
         r.block_addr = $urandom();
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: a strobed result is taken at the edge ending its cycle.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      grant_entry_type head;
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (rsp_data.status == bal_pkg::ST_NOMEM)   nomem_seen++;
         if (rsp_data.status == bal_pkg::ST_NOTLAST) notlast_seen++;
         if (grant_q.size() == 0) begin
            note_failure($sformatf("ERROR: result with no request pending: addr %h status %0d",
                                   rsp_data.addr, rsp_data.status));
         end else begin
            head = grant_q.pop_front();
            if (rsp_data.addr !== head.rsp.addr || rsp_data.status !== head.rsp.status)
               note_failure($sformatf(
                  "ERROR: request %0d: expected addr %h status %0d, got addr %h status %0d",
                  head.seq, head.rsp.addr, head.rsp.status, rsp_data.addr, rsp_data.status));
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TIMEOUT after %0d cycles with %0d results outstanding",
               cycle_count, grant_q.size());
      $display("bump_allocator_last_block_core test failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int               ph;
      int               k;
      int               pct;
      int               count;
      logic [31:0]      base_val;
      logic [31:0]      limit_val;
      logic [63:0]      tight;
      bal_pkg::rsp_type none;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= bal_pkg::CSR_HEAP_BASE;
      csr_wdata <= '0;
      start_level   = 1'b0;
      none          = '0;
      error_count   = 0;
      items_sent    = 0;
      results_seen  = 0;
      nomem_seen    = 0;
      notlast_seen  = 0;
      reg_writes    = 0;
      drain_pauses  = 0;

      // model mirror of the reset state
      arena_base       = '0;
      arena_limit      = WORD_MASK;
      arena_free_ptr   = '0;
      arena_free_count = '0;
      arena_last_addr  = '0;
      arena_last_size  = '0;
      arena_break      = '0;
      arena_started    = 1'b0;

      // Directed table. Typed expectations are the obvious ones; the rest
      // come from the model.
      // base that cannot be aligned without leaving the 32-bit range
      directed_rows.push_back(row_reg(bal_pkg::CSR_HEAP_BASE, 32'hFFFF_FFFD));
      // nothing allocated yet: no last block
      directed_rows.push_back(row_req(bal_pkg::OP_FREE, 24'd0, 32'd0, 1'b0, 1'b1,
                                      32'd0, bal_pkg::ST_NOTLAST));
      directed_rows.push_back(row_req(bal_pkg::OP_RESIZE, 24'd0, 32'd0, 1'b0, 1'b1,
                                      32'd0, bal_pkg::ST_NOTLAST));
      directed_rows.push_back(row_req(bal_pkg::OP_NONE, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1,
                                      32'd0, bal_pkg::ST_OK));
      directed_rows.push_back(row_req(bal_pkg::OP_ALLOC, 24'd0, 32'd0, 1'b0, 1'b1,
                                      32'd0, bal_pkg::ST_NOMEM));
      // base alignment runs into the limit
      directed_rows.push_back(row_reg(bal_pkg::CSR_HEAP_BASE,  32'h0000_0013));
      directed_rows.push_back(row_reg(bal_pkg::CSR_HEAP_LIMIT, 32'h0000_0014));
      directed_rows.push_back(row_req(bal_pkg::OP_ALLOC, 24'd0, 32'd0, 1'b0, 1'b1,
                                      32'd0, bal_pkg::ST_NOMEM));
      // alignment fits but the first chunk does not
      directed_rows.push_back(row_reg(bal_pkg::CSR_HEAP_LIMIT, 32'h0000_1000));
      directed_rows.push_back(row_req(bal_pkg::OP_ALLOC, 24'd1, 32'd0, 1'b0, 1'b1,
                                      32'd0, bal_pkg::ST_NOMEM));
      directed_rows.push_back(row_reg(bal_pkg::CSR_HEAP_LIMIT, 32'hFFFF_FFFF));
      directed_rows.push_back(row_req(bal_pkg::OP_ALLOC, 24'd1, 32'd0, 1'b0, 1'b1,
                                      32'h18, bal_pkg::ST_OK));
      // base write after start must not move the break
      directed_rows.push_back(row_reg(bal_pkg::CSR_HEAP_BASE,  32'h0000_0000));
      directed_rows.push_back(row_req(bal_pkg::OP_RESIZE, 24'd8, 32'h18, 1'b0, 1'b1,
                                      32'h18, bal_pkg::ST_OK));
      directed_rows.push_back(row_req(bal_pkg::OP_RESIZE, 24'd3, 32'h18, 1'b0, 1'b1,
                                      32'h18, bal_pkg::ST_OK));
      directed_rows.push_back(row_req(bal_pkg::OP_RESIZE, 24'h20, 32'h18, 1'b0, 1'b0,
                                      32'd0, bal_pkg::ST_OK));
      directed_rows.push_back(row_req(bal_pkg::OP_RESIZE, 24'h10, 32'h20, 1'b0, 1'b1,
                                      32'd0, bal_pkg::ST_NOTLAST));
      directed_rows.push_back(row_req(bal_pkg::OP_RESIZE, 24'hFF_FFFF, 32'h18, 1'b0, 1'b0,
                                      32'd0, bal_pkg::ST_OK));
      directed_rows.push_back(row_req(bal_pkg::OP_ALLOC, 24'hFF_FFFF, 32'd0, 1'b0, 1'b0,
                                      32'd0, bal_pkg::ST_OK));
      directed_rows.push_back(row_req(bal_pkg::OP_FREE, 24'd0, 32'h18, 1'b0, 1'b1,
                                      32'd0, bal_pkg::ST_NOTLAST));
      directed_rows.push_back(row_req(bal_pkg::OP_FREE, 24'd0, 32'd0, 1'b1, 1'b1,
                                      32'd0, bal_pkg::ST_OK));
      // zero limit: only space already below the break is usable
      directed_rows.push_back(row_reg(bal_pkg::CSR_HEAP_LIMIT, 32'h0000_0000));
      directed_rows.push_back(row_req(bal_pkg::OP_ALLOC, 24'hFF_FFFF, 32'd0, 1'b0, 1'b0,
                                      32'd0, bal_pkg::ST_OK));
      directed_rows.push_back(row_req(bal_pkg::OP_ALLOC, 24'hFF_FFFF, 32'd0, 1'b0, 1'b0,
                                      32'd0, bal_pkg::ST_OK));
      directed_rows.push_back(row_req(bal_pkg::OP_RESIZE, 24'd0, 32'd0, 1'b1, 1'b0,
                                      32'd0, bal_pkg::ST_OK));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_reg)
            program_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val,
                        (i + 1 < directed_rows.size()) && directed_rows[i + 1].is_reg);
         else
            issue(directed_rows[i].req, directed_rows[i].at_last, directed_rows[i].fixed,
                  directed_rows[i].typed_rsp);
      end
      directed_sent = items_sent;

      // Random phases: each sets both registers, then runs with its own idle rate.
      for (ph = 0; ph < PHASES; ph++) begin
         tight = arena_break + 64'($urandom_range(0, 12288));
         case (ph)
            0: begin base_val = $urandom();    limit_val = 32'hFFFF_FFFF; pct = 0;  count = 330; end
            1: begin base_val = 32'hFFFF_FFFF;
                     limit_val = (tight > WORD_MASK) ? 32'hFFFF_FFFF : tight[31:0];
                     pct = 47; count = 230; end
            2: begin base_val = 32'd0;         limit_val = 32'd0;         pct = 0;  count = 150; end
            3: begin base_val = $urandom();    limit_val = $urandom();    pct = 32; count = 200; end
            // fill toward the top of the address space
            4: begin base_val = $urandom();    limit_val = 32'hFFFF_FFFF; pct = 32; count = 360; end
            default: begin
               base_val  = 32'hFFFF_FFFF;
               limit_val = (tight > WORD_MASK) ? 32'hFFFF_FFFF : tight[31:0];
               pct = 47; count = 130;
            end
         endcase
         program_reg(bal_pkg::CSR_HEAP_BASE, base_val, 1'b1);
         program_reg(bal_pkg::CSR_HEAP_LIMIT, limit_val, 1'b0);
         for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) == 0) begin
               wait_all_granted();
               drain_pauses++;
            end
            sender_idle(pct);
            issue(random_request(ph == 4), 1'b0, 1'b0, none);
         end
      end

      // drain, then give stray strobes a chance to show up
      wait_all_granted();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (grant_q.size() != 0)
         note_failure($sformatf("ERROR: %0d results never arrived", grant_q.size()));

      $display("Covered %0d requests (%0d directed), %0d register writes, %0d drain pauses.",
               items_sent, directed_sent, reg_writes, drain_pauses);
      $display("Checked %0d results: %0d out of memory, %0d not last block; %0d errors.",
               results_seen, nomem_seen, notlast_seen, error_count);
      if (error_count == 0)
         $display("bump_allocator_last_block_core test passed");
      else
         $display("bump_allocator_last_block_core test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/bal_pkg.sv
sv/bal_ctrl.sv
sv/bal_datapath.sv
sv/bump_allocator_last_block_core.sv
sv/bal_checker.sv
tb/tb_top.sv
